FILE: design/imsu_pkg.sv
package imsu_pkg;

    // Lattice geometry. Each memory row holds one full line of sites along z.
    localparam int SIDE_X = 16;
    localparam int SIDE_Y = 16;
    localparam int SIDE_Z = 16;
    localparam int XW     = $clog2(SIDE_X);
    localparam int YW     = $clog2(SIDE_Y);
    localparam int ZW     = $clog2(SIDE_Z);
    localparam int ROWS   = SIDE_X * SIDE_Y;
    localparam int RW     = $clog2(ROWS);

    // Port field widths.
    localparam int ACT_W   = 2;
    localparam int COORD_W = 4;
    localparam int RND_W   = 24;

    // Acceptance levels and configuration port.
    localparam int LEVEL_N    = 6;
    localparam int LEVEL_W    = 25;
    localparam int LVL_IW     = $clog2(LEVEL_N);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEVEL_W;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_6  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 3'd7;

    // Action codes on the input port.
    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;

    // Six nearest neighbors and the width of a count of them.
    localparam int NBR_N = 6;
    localparam int CNT_W = $clog2(NBR_N + 1);

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_UPDATE,
        KIND_READ,
        KIND_OUTSIDE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [ZW-1:0]     z;
        logic              spin;
        logic [RND_W-1:0]  rnd;
    } entry_t;

    typedef struct packed {
        logic [LEVEL_N-1:0][LEVEL_W-1:0] level;
        logic                            periodic;
        logic                            coupling_negative;
    } cfg_t;

    function automatic logic [RW-1:0] row_addr(logic [XW-1:0] x, logic [YW-1:0] y);
        return RW'(int'(x) * SIDE_Y + int'(y));
    endfunction

endpackage

FILE: design/imsu_front.sv
module imsu_front
    import imsu_pkg::*;
(
    input  logic               start,
    input  logic               full,
    input  logic [ACT_W-1:0]   action,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    input  logic               spin_in,
    input  logic [RND_W-1:0]   random_fraction,
    output logic               push,
    output entry_t             entry
);

    logic outside;

    assign outside = (int'(pos_x) >= SIDE_X) || (int'(pos_y) >= SIDE_Y)
                     || (int'(pos_z) >= SIDE_Z);

    assign push = start && !full;

    always_comb
    begin
        entry.x    = XW'(pos_x);
        entry.y    = YW'(pos_y);
        entry.z    = ZW'(pos_z);
        entry.spin = spin_in;
        entry.rnd  = random_fraction;
        if (outside)
        begin
            entry.kind = KIND_OUTSIDE;
        end
        else
        begin
            // Both action codes that the package leaves unnamed are served as a read.
            case (action)
                ACT_WRITE:  entry.kind = KIND_WRITE;
                ACT_UPDATE: entry.kind = KIND_UPDATE;
                default:    entry.kind = KIND_READ;
            endcase
        end
    end

endmodule

FILE: design/imsu_queue.sv
module imsu_queue
    import imsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   valid,
    output entry_t head,
    output logic   full
);

    entry_t           entries_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == QCW'(QDEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");
`endif

endmodule

FILE: design/imsu_back.sv
module imsu_back
    import imsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_valid,
    input  entry_t q_entry,
    output logic   q_pop,
    output logic   done,
    output logic   spin_out,
    output logic   flipped
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FETCH0 = 5'b00010,
        ST_FETCH1 = 5'b00100,
        ST_FETCH2 = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    entry_t cur_reg;

    logic [SIDE_Z-1:0] lattice_mem [ROWS];
    logic [SIDE_Z-1:0] rd_a_reg;
    logic [SIDE_Z-1:0] rd_b_reg;
    logic [RW-1:0]     addr_a;
    logic [RW-1:0]     addr_b;
    logic [RW-1:0]     wr_row;
    logic [ZW-1:0]     wr_col;
    logic              wr_bit;
    logic              mem_we;

    logic [XW-1:0] xm;
    logic [XW-1:0] xp;
    logic [YW-1:0] ym;
    logic [YW-1:0] yp;
    logic [ZW-1:0] zm;
    logic [ZW-1:0] zp;

    // Neighbor order: x-1, x+1, y-1, z-1, z+1, and y+1 last (read in the decide cycle).
    logic              s_reg;
    logic [NBR_N-2:0]  nb_reg;
    logic [NBR_N-1:0]  nb_all;
    logic [NBR_N-1:0]  nb_ok;
    logic [NBR_N-1:0]  agree;
    logic [NBR_N-1:0]  oppose;
    logic              align;
    logic [CNT_W-1:0]  pc;
    logic [CNT_W-1:0]  nc;
    logic [CNT_W-1:0]  k;
    logic [LEVEL_W-1:0] level;
    logic              flip;
    logic              new_spin;

    logic done_reg;
    logic spin_reg;
    logic flip_reg;

    assign done     = done_reg;
    assign spin_out = spin_reg;
    assign flipped  = flip_reg;

    // Neighbor coordinates always wrap; open edges are masked out by nb_ok.
    assign xm = (cur_reg.x == '0) ? XW'(SIDE_X - 1) : cur_reg.x - 1'b1;
    assign xp = (cur_reg.x == XW'(SIDE_X - 1)) ? '0 : cur_reg.x + 1'b1;
    assign ym = (cur_reg.y == '0) ? YW'(SIDE_Y - 1) : cur_reg.y - 1'b1;
    assign yp = (cur_reg.y == YW'(SIDE_Y - 1)) ? '0 : cur_reg.y + 1'b1;
    assign zm = (cur_reg.z == '0) ? ZW'(SIDE_Z - 1) : cur_reg.z - 1'b1;
    assign zp = (cur_reg.z == ZW'(SIDE_Z - 1)) ? '0 : cur_reg.z + 1'b1;

    assign nb_ok = {
        cfg.periodic || (cur_reg.y != YW'(SIDE_Y - 1)),
        cfg.periodic || (cur_reg.z != ZW'(SIDE_Z - 1)),
        cfg.periodic || (cur_reg.z != '0),
        cfg.periodic || (cur_reg.y != '0),
        cfg.periodic || (cur_reg.x != XW'(SIDE_X - 1)),
        cfg.periodic || (cur_reg.x != '0)
    };

    // k counts neighbors that lower the bond energy minus those that raise it.
    assign nb_all   = {rd_a_reg[cur_reg.z], nb_reg};
    assign align    = s_reg ^ cfg.coupling_negative;
    assign agree    = nb_ok & ~(nb_all ^ {NBR_N{align}});
    assign oppose   = nb_ok & (nb_all ^ {NBR_N{align}});
    assign pc       = CNT_W'($countones(agree));
    assign nc       = CNT_W'($countones(oppose));
    assign k        = pc - nc;
    assign level    = cfg.level[LVL_IW'(k - CNT_W'(1))];
    assign flip     = (pc <= nc) || (level > LEVEL_W'(cur_reg.rnd));
    assign new_spin = s_reg ^ flip;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        addr_a     = row_addr(cur_reg.x, cur_reg.y);
        addr_b     = row_addr(xm, cur_reg.y);
        mem_we     = 1'b0;
        wr_row     = row_addr(q_entry.x, q_entry.y);
        wr_col     = q_entry.z;
        wr_bit     = q_entry.spin;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_entry.kind)
                        KIND_WRITE:   mem_we = 1'b1;
                        KIND_OUTSIDE: state_next = ST_IDLE;
                        default:      state_next = ST_FETCH0;
                    endcase
                end
            end
            ST_FETCH0:
            begin
                state_next = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                addr_a     = row_addr(xp, cur_reg.y);
                addr_b     = row_addr(cur_reg.x, ym);
                state_next = (cur_reg.kind == KIND_UPDATE) ? ST_FETCH2 : ST_IDLE;
            end
            ST_FETCH2:
            begin
                addr_a     = row_addr(cur_reg.x, yp);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                mem_we     = 1'b1;
                wr_row     = row_addr(cur_reg.x, cur_reg.y);
                wr_col     = cur_reg.z;
                wr_bit     = new_spin;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= lattice_mem[addr_a];
        rd_b_reg <= lattice_mem[addr_b];
        if (mem_we)
        begin
            lattice_mem[wr_row][wr_col] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
        if (state_reg == ST_FETCH1)
        begin
            s_reg     <= rd_a_reg[cur_reg.z];
            nb_reg[0] <= rd_b_reg[cur_reg.z];
            nb_reg[3] <= rd_a_reg[zm];
            nb_reg[4] <= rd_a_reg[zp];
        end
        if (state_reg == ST_FETCH2)
        begin
            nb_reg[1] <= rd_a_reg[cur_reg.z];
            nb_reg[2] <= rd_b_reg[cur_reg.z];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            spin_reg  <= 1'b0;
            flip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (q_pop && (q_entry.kind == KIND_WRITE))
            begin
                done_reg <= 1'b1;
                spin_reg <= q_entry.spin;
                flip_reg <= 1'b0;
            end
            else if (q_pop && (q_entry.kind == KIND_OUTSIDE))
            begin
                done_reg <= 1'b1;
                spin_reg <= 1'b0;
                flip_reg <= 1'b0;
            end
            else if ((state_reg == ST_FETCH1) && (cur_reg.kind != KIND_UPDATE))
            begin
                done_reg <= 1'b1;
                spin_reg <= rd_a_reg[cur_reg.z];
                flip_reg <= 1'b0;
            end
            else if (state_reg == ST_DECIDE)
            begin
                done_reg <= 1'b1;
                spin_reg <= new_spin;
                flip_reg <= flip;
            end
        end
    end

`ifndef ASSERT_OFF
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_entry.kind == KIND_READ)) |-> ##3 done_reg)
        else $error("read item produced no result");

    a_update_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_entry.kind == KIND_UPDATE)) |-> ##5 done_reg)
        else $error("update item produced no result");

    a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH0 || state_reg == ST_FETCH1 || state_reg == ST_FETCH2)
        |-> !mem_we)
        else $error("lattice written while neighbors are fetched");

    a_flip_is_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> (flip_reg == (spin_reg != $past(s_reg))))
        else $error("flip flag disagrees with the spin change");
`endif

endmodule

FILE: design/ising_metropolis_site_update_core.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------------
// config    | cfg_write               | cfg_index (3), cfg_data (25)
// item in   | start high, busy low    | action, pos_x, pos_y, pos_z, spin_in,
//           |                         | random_fraction
// result    | done, one cycle         | spin_out, flipped
//
// A write or an out-of-range item finishes in the pop state; a read goes through pop,
// FETCH0 and FETCH1; a Metropolis update through pop, FETCH0 to FETCH2 (which read
// five lattice rows over two read ports, whose count sets the fetch states), then DECIDE
// (decision and write-back). Result appears the cycle after the item's last state.
// The front takes a new item whenever the two-entry queue is not full.
// Reset clears the configuration to its defaults and empties the queue;
// the lattice itself is not cleared and must be written before it is read.
// The receiver cannot stall: done is high for exactly one cycle per item.
module ising_metropolis_site_update_core
    import imsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [ACT_W-1:0]      action,
    input  logic [COORD_W-1:0]    pos_x,
    input  logic [COORD_W-1:0]    pos_y,
    input  logic [COORD_W-1:0]    pos_z,
    input  logic                  spin_in,
    input  logic [RND_W-1:0]      random_fraction,
    output logic                  done,
    output logic                  spin_out,
    output logic                  flipped
);

    // Configuration registers. The acceptance levels hold exp(-2|J|k/kT) as
    // a fraction of 2^24; a value of 2^24 makes that energy step always accepted.
    logic [LEVEL_N-1:0][LEVEL_W-1:0] level_reg;
    logic                            periodic_reg;
    logic                            coupling_reg;
    cfg_t                            cfg;

    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    entry_t push_entry;
    entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            periodic_reg <= 1'b1;
            coupling_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index inside {[REG_LEVEL_1:REG_LEVEL_6]})
            begin
                level_reg[LVL_IW'(cfg_index)] <= cfg_data[LEVEL_W-1:0];
            end
            else
            begin
                case (cfg_index)
                    REG_PERIODIC: periodic_reg <= cfg_data[0];
                    REG_COUPLING: coupling_reg <= cfg_data[0];
                    default:      periodic_reg <= periodic_reg;
                endcase
            end
        end
    end

    assign cfg.level             = level_reg;
    assign cfg.periodic          = periodic_reg;
    assign cfg.coupling_negative = coupling_reg;

    // The front is ready whenever the queue has room, independent of the back end.
    assign busy = q_full;

    // Front: takes an item and tags it as write, update, read or out of range.
    imsu_front u_front (
        .start           (start),
        .full            (q_full),
        .action          (action),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .spin_in         (spin_in),
        .random_fraction (random_fraction),
        .push            (q_push),
        .entry           (push_entry)
    );

    // Short queue that decouples item intake from the lattice sequencer.
    imsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head),
        .full       (q_full)
    );

    // Back: owns the lattice memory and runs each item to completion in order,
    // so a write always lands before any later item reads that site.
    imsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_entry  (q_head),
        .q_pop    (q_pop),
        .done     (done),
        .spin_out (spin_out),
        .flipped  (flipped)
    );

endmodule

FILE: tb/testbench.sv
module testbench;
    import imsu_pkg::*;

    // Read codes are not named in the package. The spare code 3 must behave
    // exactly like a read.
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int                 SITES         = SIDE_X * SIDE_Y * SIDE_Z;
    localparam logic [LEVEL_W-1:0] LEVEL_ALWAYS  = 25'h1000000;
    localparam logic [RND_W-1:0]   RND_MAX       = '1;
    localparam longint             RND_TOP       = 64'sd16777215;
    localparam int                 RANDOM_ITEMS  = 1150;
    localparam int                 PHASES        = 8;
    localparam int                 IDLE_PERCENT  = 18;
    localparam int                 SETTLE_CYCLES = 20;
    localparam int unsigned        CYCLE_LIMIT   = 200000;

    // One predicted result, together with the item that caused it so that a
    // mismatch report can say which site went wrong.
    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               spin;
        logic               flip;
    } site_result_t;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  cfg_write       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [ACT_W-1:0]      action          = '0;
    logic [COORD_W-1:0]    pos_x           = '0;
    logic [COORD_W-1:0]    pos_y           = '0;
    logic [COORD_W-1:0]    pos_z           = '0;
    logic                  spin_in         = 1'b0;
    logic [RND_W-1:0]      random_fraction = '0;
    logic                  done;
    logic                  spin_out;
    logic                  flipped;

    // Shadow copy of the lattice and the settings. The written map keeps the
    // stimulus from ever touching a site whose contents are still undefined.
    bit           lattice [SITES];
    bit           written [SITES];
    cfg_t         model_cfg;
    site_result_t expected_sites[$];
    int           mismatch_count = 0;
    int           items_sent     = 0;
    bit           idle_enable    = 1'b1;
    int           walk_x         = 0;
    int           walk_y         = 0;
    int           walk_z         = 0;

    ising_metropolis_site_update_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .spin_in         (spin_in),
        .random_fraction (random_fraction),
        .done            (done),
        .spin_out        (spin_out),
        .flipped         (flipped)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int site_of(int x, int y, int z);
        return (x * SIDE_Y + y) * SIDE_Z + z;
    endfunction

    // Member j of the cross around a site: j = 0 is the site itself, and
    // j = 1..6 walk the three axes in the order minus, plus. The lattice
    // wraps here regardless of the boundary setting, because the stimulus
    // uses this only to pick sites and to decide which sites must hold known spins.
    function automatic void cross_member(input int x, input int y, input int z, input int j,
                                         output int nx, output int ny, output int nz);
        int axis;
        int dir;
        nx = x;
        ny = y;
        nz = z;
        if (j > 0)
        begin
            axis = (j - 1) / 2;
            dir  = ((j - 1) % 2 == 1) ? 1 : -1;
            case (axis)
                0: nx = (x + dir + SIDE_X) % SIDE_X;
                1: ny = (y + dir + SIDE_Y) % SIDE_Y;
                default: nz = (z + dir + SIDE_Z) % SIDE_Z;
            endcase
        end
    endfunction

    // An update may only be issued once the site and all six neighbors,
    // wrapped or not, have been written at least once.
    function automatic bit cross_ready(int x, int y, int z);
        int nx;
        int ny;
        int nz;
        for (int j = 0; j < 7; j++)
        begin
            cross_member(x, y, z, j, nx, ny, nz);
            if (!written[site_of(nx, ny, nz)])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Contribution of one neighbor as -1 or +1, or 0 when it lies beyond an
    // open edge.
    function automatic int neighbor_spin(int x, int y, int z, int axis, int dir);
        int c[3];
        int sides[3];
        int n;
        c     = '{x, y, z};
        sides = '{SIDE_X, SIDE_Y, SIDE_Z};
        n     = c[axis] + dir;
        if (n < 0 || n >= sides[axis])
        begin
            if (!model_cfg.periodic)
                return 0;
            n = (n + sides[axis]) % sides[axis];
        end
        c[axis] = n;
        return lattice[site_of(c[0], c[1], c[2])] ? 1 : -1;
    endfunction

    // Applies one item to the shadow lattice and returns the result that the
    // block must produce for it.
    function automatic site_result_t metropolis_predict(logic [ACT_W-1:0] act, int x, int y,
                                                        int z, logic spin,
                                                        logic [RND_W-1:0] rnd);
        site_result_t res;
        int           idx;
        int           k;
        res.act  = act;
        res.x    = COORD_W'(x);
        res.y    = COORD_W'(y);
        res.z    = COORD_W'(z);
        res.flip = 1'b0;
        idx      = site_of(x, y, z);
        if (act == ACT_WRITE)
        begin
            lattice[idx] = spin;
            written[idx] = 1'b1;
        end
        else if (act == ACT_UPDATE)
        begin
            k = 0;
            for (int axis = 0; axis < 3; axis++)
            begin
                k += neighbor_spin(x, y, z, axis, -1);
                k += neighbor_spin(x, y, z, axis, 1);
            end
            if (!lattice[idx])
                k = -k;
            if (model_cfg.coupling_negative)
                k = -k;
            // A flip that lowers or keeps the energy is always taken; a rise
            // of 2|J|k is taken when its level beats the random fraction.
            if (k <= 0)
                res.flip = 1'b1;
            else if (model_cfg.level[k-1] > rnd)
                res.flip = 1'b1;
            if (res.flip)
                lattice[idx] = ~lattice[idx];
        end
        res.spin = lattice[idx];
        return res;
    endfunction

    // Presents one item and holds it until the block takes it. Idle cycles
    // are inserted before the item at random, and the prediction is made at
    // the accepting edge so that it follows the block's own item order.
    task automatic send_item(input logic [ACT_W-1:0] act, input int x, input int y,
                             input int z, input logic spin, input logic [RND_W-1:0] rnd);
        @(negedge clk);
        while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start           <= 1'b1;
        action          <= act;
        pos_x           <= COORD_W'(x);
        pos_y           <= COORD_W'(y);
        pos_z           <= COORD_W'(z);
        spin_in         <= spin;
        random_fraction <= rnd;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_sites.push_back(metropolis_predict(act, x, y, z, spin, rnd));
        items_sent++;
    endtask

    // Drops start and waits until every result has come back and the back
    // end has had time to finish its write-back.
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (expected_sites.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all eight registers. The one-bit registers get random upper
    // data bits, which the block must ignore.
    task automatic load_settings(input cfg_t setting);
        for (int i = 0; i < LEVEL_N; i++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(REG_LEVEL_1 + i);
            cfg_data  <= setting.level[i];
        end
        @(negedge clk);
        cfg_index <= REG_PERIODIC;
        cfg_data  <= CFG_DATA_W'({$urandom(), setting.periodic});
        @(negedge clk);
        cfg_index <= REG_COUPLING;
        cfg_data  <= CFG_DATA_W'({$urandom(), setting.coupling_negative});
        @(negedge clk);
        cfg_write <= 1'b0;
        model_cfg = setting;
    endtask

    function automatic cfg_t uniform_setting(logic [LEVEL_W-1:0] level, logic periodic,
                                             logic coupling_negative);
        cfg_t setting;
        for (int i = 0; i < LEVEL_N; i++)
            setting.level[i] = level;
        setting.periodic          = periodic;
        setting.coupling_negative = coupling_negative;
        return setting;
    endfunction

    // Coordinates lean toward the lowest and highest coordinate so that wrap and open-edge
    // handling is hit often.
    function automatic int pick_coord(int side);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return side - 1;
            default: return $urandom_range(0, side - 1);
        endcase
    endfunction

    // Random fractions: the two extremes, values right around one of the
    // current acceptance levels, and plain uniform values.
    function automatic logic [RND_W-1:0] pick_fraction();
        longint near;
        int     offset;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return RND_MAX;
            2, 3:
            begin
                offset = int'($urandom_range(0, 2)) - 1;
                near   = longint'(model_cfg.level[$urandom_range(0, LEVEL_N - 1)]) + offset;
                if (near < 0)
                    near = 0;
                if (near > RND_TOP)
                    near = RND_TOP;
                return RND_W'(near);
            end
            default: return RND_W'($urandom());
        endcase
    endfunction

    // One burst of work around a wandering site: fill in its neighborhood,
    // then a few updates and reads nearby, and stray writes anywhere.
    task automatic run_episode();
        int nx;
        int ny;
        int nz;
        int pick;
        if ($urandom_range(0, 9) < 6)
        begin
            cross_member(walk_x, walk_y, walk_z, $urandom_range(1, 6), nx, ny, nz);
            walk_x = nx;
            walk_y = ny;
            walk_z = nz;
        end
        else
        begin
            walk_x = pick_coord(SIDE_X);
            walk_y = pick_coord(SIDE_Y);
            walk_z = pick_coord(SIDE_Z);
        end
        for (int j = 0; j < 7; j++)
        begin
            cross_member(walk_x, walk_y, walk_z, j, nx, ny, nz);
            if (!written[site_of(nx, ny, nz)] || $urandom_range(0, 9) == 0)
                send_item(ACT_WRITE, nx, ny, nz, 1'($urandom_range(0, 1)), RND_W'($urandom()));
        end
        repeat ($urandom_range(1, 4))
        begin
            cross_member(walk_x, walk_y, walk_z, $urandom_range(0, 6), nx, ny, nz);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if (!cross_ready(nx, ny, nz))
                begin
                    nx = walk_x;
                    ny = walk_y;
                    nz = walk_z;
                end
                send_item(ACT_UPDATE, nx, ny, nz, 1'($urandom_range(0, 1)), pick_fraction());
            end
            else if (pick < 85)
            begin
                send_item((pick < 78) ? ACT_READ : ACT_SPARE, nx, ny, nz,
                          1'($urandom_range(0, 1)), RND_W'($urandom()));
            end
            else
            begin
                send_item(ACT_WRITE, pick_coord(SIDE_X), pick_coord(SIDE_Y), pick_coord(SIDE_Z),
                          1'($urandom_range(0, 1)), RND_W'($urandom()));
            end
        end
    endtask

    // Runs under the reset settings: the corner site and its wrapped
    // neighbors all hold +1, the spare action code reads it back, and with
    // every level at zero an energy rise is never accepted.
    task automatic test_corner_defaults();
        int nx;
        int ny;
        int nz;
        for (int j = 0; j < 7; j++)
        begin
            cross_member(0, 0, 0, j, nx, ny, nz);
            send_item(ACT_WRITE, nx, ny, nz, 1'b1, RND_W'($urandom()));
        end
        send_item(ACT_SPARE, 0, 0, 0, 1'b0, RND_MAX);
        send_item(ACT_UPDATE, 0, 0, 0, 1'b1, '0);
    endtask

    // A level of exactly 2^24 must beat even the largest random fraction.
    // The second update then sees a falling energy and flips back.
    task automatic test_accept_always();
        drain_block();
        load_settings(uniform_setting(LEVEL_ALWAYS, 1'b1, 1'b0));
        send_item(ACT_UPDATE, 0, 0, 0, 1'b0, RND_MAX);
        send_item(ACT_UPDATE, 0, 0, 0, 1'b1, RND_MAX);
    endtask

    // Three of the six neighbors are turned to -1, so the neighbor sum is
    // zero; with every level at zero the flip must still be taken.
    task automatic test_zero_energy_flip();
        int nx;
        int ny;
        int nz;
        for (int j = 2; j <= 6; j += 2)
        begin
            cross_member(0, 0, 0, j, nx, ny, nz);
            send_item(ACT_WRITE, nx, ny, nz, 1'b0, RND_W'($urandom()));
        end
        drain_block();
        load_settings(uniform_setting('0, 1'b1, 1'b0));
        send_item(ACT_UPDATE, 0, 0, 0, 1'b1, '0);
    endtask

    // Open edges with antiferromagnetic coupling at both far corners, with
    // every level one below always.
    task automatic test_open_antiferro();
        int nx;
        int ny;
        int nz;
        drain_block();
        load_settings(uniform_setting(LEVEL_W'(RND_MAX), 1'b0, 1'b1));
        send_item(ACT_UPDATE, 0, 0, 0, 1'b0, RND_MAX);
        for (int j = 0; j < 7; j++)
        begin
            cross_member(SIDE_X - 1, SIDE_Y - 1, SIDE_Z - 1, j, nx, ny, nz);
            send_item(ACT_WRITE, nx, ny, nz, 1'(j % 2), RND_W'($urandom()));
        end
        send_item(ACT_UPDATE, SIDE_X - 1, SIDE_Y - 1, SIDE_Z - 1, 1'b0, '0);
        send_item(ACT_READ, SIDE_X - 1, SIDE_Y - 1, SIDE_Z - 1, 1'b1, RND_MAX);
    endtask

    // Random traffic in several phases. The first three phases use the
    // extreme settings, the rest random levels and modes. One phase runs
    // without any idle cycles so that items arrive back to back.
    task automatic test_random_phases();
        cfg_t setting;
        int   target;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: setting = uniform_setting('0, 1'b1, 1'b0);
                1: setting = uniform_setting(LEVEL_ALWAYS, 1'b0, 1'b1);
                2: setting = uniform_setting(LEVEL_W'(RND_MAX), 1'b1, 1'b1);
                default:
                begin
                    for (int i = 0; i < LEVEL_N; i++)
                        setting.level[i] = LEVEL_W'($urandom_range(0, LEVEL_ALWAYS));
                    setting.periodic          = 1'($urandom_range(0, 1));
                    setting.coupling_negative = 1'($urandom_range(0, 1));
                end
            endcase
            drain_block();
            load_settings(setting);
            idle_enable = (phase != 3);
            target      = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                run_episode();
        end
        idle_enable = 1'b1;
    endtask

    // Every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        site_result_t want;
        if (done === 1'b1)
        begin
            if (expected_sites.size() == 0)
            begin
                $display("%0t: unexpected result, spin_out %b flipped %b", $time, spin_out,
                         flipped);
                mismatch_count++;
            end
            else
            begin
                want = expected_sites.pop_front();
                if (spin_out !== want.spin)
                begin
                    $display("%0t: spin_out at (%0d,%0d,%0d) action %0d: expected %b, got %b",
                             $time, want.x, want.y, want.z, want.act, want.spin, spin_out);
                    mismatch_count++;
                end
                if (flipped !== want.flip)
                begin
                    $display("%0t: flipped at (%0d,%0d,%0d) action %0d: expected %b, got %b",
                             $time, want.x, want.y, want.z, want.act, want.flip, flipped);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a run that has stopped making progress.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        model_cfg = uniform_setting('0, 1'b1, 1'b0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_defaults();
        test_accept_always();
        test_zero_energy_flip();
        test_open_antiferro();
        test_random_phases();

        drain_block();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
design/imsu_pkg.sv
design/imsu_front.sv
design/imsu_queue.sv
design/imsu_back.sv
design/ising_metropolis_site_update_core.sv
tb/testbench.sv
